@@ src/sorted_priority_queue_core_macros.svh @@
// Assertion helpers, clocked on clk_i and disabled during reset.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Consequent holds in the same cycle.
`define SPQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Consequent holds in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

@@ src/spq_pkg.sv @@
package spq_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned OCC_W        = 5;
  localparam int unsigned CAPACITY_DEF = 16;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } spq_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_RD,
    ST_ENQ_CMP,
    ST_ENQ_WR,
    ST_DEQ_RD,
    ST_DEQ_DATA,
    ST_DONE
  } spq_state_e;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] value;
    spq_status_e              status;
    logic [OCC_W-1:0]         occupancy;
  } spq_res_t;

endpackage

@@ src/spq_mem.sv @@
module spq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic signed [spq_pkg::DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]                    raddr_i,
  output logic signed [spq_pkg::DATA_W-1:0] rdata_o
);
  import spq_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/spq_ctrl.sv @@
module spq_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned AW       = $clog2(CAPACITY),
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic signed [spq_pkg::DATA_W-1:0] in_value_i,
  input  logic                              out_ready_i,
  output spq_pkg::spq_res_t                 res_o,
  output logic                              mem_we_o,
  output logic [AW-1:0]                     mem_waddr_o,
  output logic signed [spq_pkg::DATA_W-1:0] mem_wdata_o,
  output logic [AW-1:0]                     mem_raddr_o,
  input  logic signed [spq_pkg::DATA_W-1:0] mem_rdata_i
);
  import spq_pkg::*;

  spq_state_e               state_q, state_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  spq_status_e              status_q, status_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [AW-1:0]            head_q, head_d;

  logic          accept;
  logic          full;
  logic          empty;
  logic          less;
  logic [CW-1:0] roff;
  logic [CW:0]   rsum;
  logic [CW:0]   wsum;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign full   = (count_q == CW'(CAPACITY));
  assign empty  = (count_q == '0);
  // Shared comparator: stored entry against the value being inserted.
  assign less   = (mem_rdata_i < val_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_ENQ) begin
            if (full) state_d = ST_DONE;
            else if (empty) state_d = ST_ENQ_WR;
            else state_d = ST_ENQ_RD;
          end else begin
            if (empty) state_d = ST_DONE;
            else state_d = ST_DEQ_RD;
          end
        end
      end
      ST_ENQ_RD:   state_d = ST_ENQ_CMP;
      ST_ENQ_CMP: begin
        if (less || (idx_q == CW'(1))) state_d = ST_ENQ_WR;
      end
      ST_ENQ_WR:   state_d = ST_DONE;
      ST_DEQ_RD:   state_d = ST_DEQ_DATA;
      ST_DEQ_DATA: state_d = ST_DONE;
      ST_DONE: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we_o    = 1'b0;
    mem_wdata_o = val_q;
    roff        = '0;
    case (state_q)
      ST_ENQ_RD: roff = idx_q - CW'(1);
      ST_ENQ_CMP: begin
        // Shift the entry up one slot and fetch the one below it.
        if (!less) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i;
          if (idx_q > CW'(1)) roff = idx_q - CW'(2);
        end
      end
      ST_ENQ_WR: mem_we_o = 1'b1;
      default: ;
    endcase
  end

  // Logical position to physical slot of the ring.
  always_comb begin
    rsum = (CW+1)'(head_q) + (CW+1)'(roff);
    if (rsum >= (CW+1)'(CAPACITY)) rsum = rsum - (CW+1)'(CAPACITY);
    wsum = (CW+1)'(head_q) + (CW+1)'(idx_q);
    if (wsum >= (CW+1)'(CAPACITY)) wsum = wsum - (CW+1)'(CAPACITY);
  end

  assign mem_raddr_o = AW'(rsum);
  assign mem_waddr_o = AW'(wsum);

  // Datapath updates.
  always_comb begin
    val_d    = val_q;
    value_d  = value_q;
    status_d = status_q;
    count_d  = count_q;
    idx_d    = idx_q;
    head_d   = head_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d    = in_value_i;
          value_d  = '0;
          idx_d    = count_q;
          status_d = STAT_OK;
          if (req_type_i == REQ_ENQ && full) status_d = STAT_FULL;
          if (req_type_i == REQ_DEQ && empty) status_d = STAT_EMPTY;
        end
      end
      ST_ENQ_CMP: begin
        if (!less) idx_d = idx_q - CW'(1);
      end
      ST_ENQ_WR: count_d = count_q + CW'(1);
      ST_DEQ_DATA: begin
        value_d = mem_rdata_i;
        count_d = count_q - CW'(1);
        head_d  = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    value_q  <= value_d;
    status_q <= status_d;
    idx_q    <= idx_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign res_o.done      = (state_q == ST_DONE) && out_ready_i;
  assign res_o.value     = value_q;
  assign res_o.status    = status_q;
  assign res_o.occupancy = OCC_W'(count_q);

endmodule

@@ src/sorted_priority_queue_core.sv @@
// Bounded min-priority queue of signed 32-bit values, kept sorted in a ring
// buffer memory with one write and one registered read port. Every request
// answers with one word: value, status and occupancy after the request. A
// dequeue reads the head entry, takes its data and waits in the done state
// until the output register is free. An enqueue reads the tail entry: a
// single comparator walks down from the tail one entry per cycle while each
// entry not smaller than the new one moves up a slot, until a smaller entry
// is found or the head has been passed; then the new value is written. One
// into an empty queue writes at once. A dequeue from an empty queue or an
// enqueue into a full one goes straight to the done state. The result word
// enters the output register as the block returns to idle. Ties go ahead
// of equal stored values. The input stalls until the result has been moved
// into the output register.
`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic signed [spq_pkg::DATA_W-1:0]  in_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [spq_pkg::DATA_W-1:0]  out_value_o,
  output logic [1:0]                         status_o,
  output logic [spq_pkg::OCC_W-1:0]          occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  spq_res_t                 res;
  logic                     out_ready;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic signed [DATA_W-1:0] mem_rdata;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_value_q;
  logic [1:0]               status_q;
  logic [OCC_W-1:0]         occ_q;

  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .in_value_i  (in_value_i),
    .out_ready_i (out_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  spq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register frees up when empty or when its word is taken.
  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.done) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      out_value_q <= res.value;
      status_q    <= res.status;
      occ_q       <= res.occupancy;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

  `SPQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `SPQ_ASSERT_SAME(a_err_value_zero, out_valid_o && status_o != STAT_OK, out_value_o == '0)
  `SPQ_ASSERT_SAME(a_full_occupancy, out_valid_o && status_o == STAT_FULL, occupancy_o == OCC_W'(CAPACITY))
  `SPQ_ASSERT_SAME(a_empty_occupancy, out_valid_o && status_o == STAT_EMPTY, occupancy_o == '0)

endmodule

@@ test/sorted_priority_queue_core_tb.sv @@
module sorted_priority_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = CAPACITY_DEF;
  localparam int unsigned NUM_DIR     = 20;
  localparam int unsigned NUM_PHASES  = 4;
  localparam int unsigned PHASE_WORDS = 308;
  localparam int unsigned LONG_HOLD   = 150;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    spq_status_e              status;
    logic [OCC_W-1:0]         occ;
  } exp_word_t;

  typedef struct packed {
    logic                     req;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    exp_word_t                want;
  } dir_row_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic                     req_type_i  = REQ_ENQ;
  logic signed [DATA_W-1:0] in_value_i  = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] out_value_o;
  logic [1:0]               status_o;
  logic [OCC_W-1:0]         occupancy_o;

  logic signed [DATA_W-1:0] stored_vals [$];
  exp_word_t                pending_words [$];
  int                       fail_count     = 0;
  int                       sender_idle_pct = 0;
  int                       recv_stall_pct  = 0;
  int                       hold_cycles     = 0;

  // Extremes, head insertion, ties, empty dequeue and full enqueue.
  dir_row_t dir_rows [NUM_DIR] = '{
    '{REQ_DEQ, 32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 5'd0}},
    '{REQ_ENQ, 32'h0000_0000, 1'b1, '{32'h0, STAT_OK, 5'd1}},
    '{REQ_ENQ, 32'h7FFF_FFFF, 1'b1, '{32'h0, STAT_OK, 5'd2}},
    '{REQ_ENQ, 32'h8000_0000, 1'b1, '{32'h0, STAT_OK, 5'd3}},
    '{REQ_ENQ, 32'h0000_0000, 1'b1, '{32'h0, STAT_OK, 5'd4}},
    '{REQ_ENQ, 32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_OK, 5'd5}},
    '{REQ_ENQ, 32'h5555_5555, 1'b0, '0},
    '{REQ_ENQ, 32'hAAAA_AAAA, 1'b0, '0},
    '{REQ_ENQ, 32'h0000_0001, 1'b0, '0},
    '{REQ_ENQ, 32'hFFFF_FFFE, 1'b0, '0},
    '{REQ_ENQ, 32'h7FFF_FFFE, 1'b0, '0},
    '{REQ_ENQ, 32'h8000_0001, 1'b0, '0},
    '{REQ_ENQ, 32'h0000_0064, 1'b0, '0},
    '{REQ_ENQ, 32'hFFFF_FF9C, 1'b0, '0},
    '{REQ_ENQ, 32'h0000_0000, 1'b0, '0},
    '{REQ_ENQ, 32'h0001_0000, 1'b0, '0},
    '{REQ_ENQ, 32'hFFFF_0000, 1'b0, '0},
    '{REQ_ENQ, 32'h0000_0005, 1'b1, '{32'h0, STAT_FULL, 5'd16}},
    '{REQ_DEQ, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, STAT_OK, 5'd15}},
    '{REQ_DEQ, 32'h1234_5678, 1'b0, '0}
  };

  sorted_priority_queue_core #(
    .CAPACITY(QUEUE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .in_value_i (in_value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_value_o(out_value_o),
    .status_o   (status_o),
    .occupancy_o(occupancy_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sorted-queue predictor: new value goes ahead of equal stored values.
  function automatic exp_word_t queue_step(input logic req, input logic signed [DATA_W-1:0] val);
    exp_word_t w;
    int        pos;
    w.value  = '0;
    w.status = STAT_OK;
    if (req == REQ_ENQ) begin
      if (stored_vals.size() >= QUEUE_DEPTH) begin
        w.status = STAT_FULL;
      end else begin
        pos = 0;
        while (pos < stored_vals.size() && stored_vals[pos] < val) pos++;
        stored_vals.insert(pos, val);
      end
    end else if (stored_vals.size() == 0) begin
      w.status = STAT_EMPTY;
    end else begin
      w.value = stored_vals.pop_front();
    end
    w.occ = OCC_W'(stored_vals.size());
    return w;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return DATA_W'(int'($urandom_range(8)) - 4);
      4: begin
        if (stored_vals.size() != 0)
          return stored_vals[$urandom_range(stored_vals.size() - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t ns: %s mismatch: got %h, want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Offer one word after a random gap, hold it until taken, then record the answer.
  task automatic send_word(input logic req, input logic signed [DATA_W-1:0] val,
                           input bit typed, input exp_word_t typed_word);
    int        gap;
    exp_word_t w;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    in_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    w = queue_step(req, val);
    pending_words.push_back(typed ? typed_word : w);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    exp_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", out_value_o, '0);
      end else begin
        w = pending_words.pop_front();
        if (out_value_o !== w.value) report_mismatch("out_value", out_value_o, w.value);
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (occupancy_o !== w.occ) report_mismatch("occupancy", occupancy_o, w.occ);
      end
    end
  end

  initial begin
    int  enq_pct;
    logic req;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_word(dir_rows[i].req, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

    enq_pct = 50;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin sender_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      wait_drained();
      // Hold the output while words keep coming, so the input backs up.
      if (phase == 2) hold_cycles = LONG_HOLD;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Swing between filling, draining and balanced traffic.
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: enq_pct = 80;
            1: enq_pct = 20;
            default: enq_pct = 50;
          endcase
        end
        req = ($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
        send_word(req, pick_value(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
